/* hdl/gcode_word_tokenizer_assert.svh */
// Assertion macros shared by the tokenizer RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef GCODE_WORD_TOKENIZER_ASSERT_SVH
`define GCODE_WORD_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define GWT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GWT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/gwt_pkg.sv */
// Shared types, constants and result builders for the G-code tokenizer.
// No dependencies.
`default_nettype none

package gwt_pkg;

  localparam int MANT_BITS = 40;
  localparam int CIDX_BITS = 16;

  localparam logic [3:0]           FRAC_MAX = 4'd15;
  localparam logic [MANT_BITS-1:0] MAG_MAX  = {1'b0, {(MANT_BITS-1){1'b1}}};

  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_Y      = 8'h59;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  typedef enum logic [1:0] {
    MODE_IDLE, MODE_CODE, MODE_SPACE, MODE_COMMENT
  } mode_t;

  typedef enum logic [1:0] {
    PH_START, PH_INT, PH_FRAC, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CODE, KIND_NUMBER, KIND_CMT_START, KIND_CMT_BYTE, KIND_CMT_END
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             letter;
    logic                   has_value;
    logic [MANT_BITS-1:0]   mantissa;
    logic [3:0]             frac_digits;
    logic                   overflow;
    logic [CIDX_BITS-1:0]   comment_index;
    logic [7:0]             comment_byte;
    logic                   last;
  } result_t;

  // results handed from the parser to the output queue for one accepted byte
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic result_t mk_number(kind_t kind, logic [7:0] letter, logic hv,
                                        logic [MANT_BITS-1:0] mant, logic [3:0] frac,
                                        logic ovf);
    result_t r;
    r.kind          = kind;
    r.letter        = letter;
    r.has_value     = hv;
    r.mantissa      = mant;
    r.frac_digits   = frac;
    r.overflow      = ovf;
    r.comment_index = '0;
    r.comment_byte  = 8'd0;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic result_t mk_comment(kind_t kind, logic [CIDX_BITS-1:0] idx,
                                         logic [7:0] cbyte);
    result_t r;
    r.kind          = kind;
    r.letter        = 8'd0;
    r.has_value     = 1'b0;
    r.mantissa      = '0;
    r.frac_digits   = 4'd0;
    r.overflow      = 1'b0;
    r.comment_index = idx;
    r.comment_byte  = cbyte;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic logic is_code_letter(logic [7:0] c);
    return (c == CH_F) || (c == CH_G) || (c == CH_M) ||
           (c == CH_X) || (c == CH_Y) || (c == CH_Z);
  endfunction

  function automatic logic is_num_char(logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || (c == CH_MINUS) || (c == CH_DOT);
  endfunction

endpackage

`default_nettype wire

/* hdl/gwt_in_if.sv */
// Input channel of the tokenizer: one text byte or a flush per beat.
// Depends on nothing.
`default_nettype none

interface gwt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_stream;

  modport source (output valid, output ch, output end_of_stream, input ready);
  modport sink   (input valid, input ch, input end_of_stream, output ready);
endinterface

`default_nettype wire

/* hdl/gwt_out_if.sv */
// Result channel of the tokenizer: one token result per beat.
// Depends on gwt_pkg for field widths.
`default_nettype none

interface gwt_out_if;
  logic                            valid;
  logic                            ready;
  logic [2:0]                      kind;
  logic [7:0]                      letter;
  logic                            has_value;
  logic signed [gwt_pkg::MANT_BITS-1:0] mantissa;
  logic [3:0]                      frac_digits;
  logic                            overflow;
  logic [gwt_pkg::CIDX_BITS-1:0]   comment_index;
  logic [7:0]                      comment_byte;
  logic                            last;

  modport source (output valid, output kind, output letter, output has_value,
                  output mantissa, output frac_digits, output overflow,
                  output comment_index, output comment_byte, output last,
                  input ready);
  modport sink   (input valid, input kind, input letter, input has_value,
                  input mantissa, input frac_digits, input overflow,
                  input comment_index, input comment_byte, input last,
                  output ready);
endinterface

`default_nettype wire

/* hdl/gwt_parse.sv */
// Tokenizer state machine: mode, number accumulator, comment counter.
// Depends on gwt_pkg and gcode_word_tokenizer_assert.svh.
`default_nettype none
`include "gcode_word_tokenizer_assert.svh"

module gwt_parse (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire logic [7:0]    ch,
  input  wire logic          eos,
  output gwt_pkg::push_t     push
);

  localparam int MB = gwt_pkg::MANT_BITS;
  localparam int CB = gwt_pkg::CIDX_BITS;

  gwt_pkg::mode_t  mode_r,   mode_nxt;
  logic [7:0]      letter_r, letter_nxt;
  gwt_pkg::phase_t phase_r,  phase_nxt;
  logic            neg_r,    neg_nxt;
  logic            seen_r,   seen_nxt;
  logic [MB-1:0]   acc_r,    acc_nxt;
  logic [3:0]      frac_r,   frac_nxt;
  logic            ovf_r,    ovf_nxt;
  logic [CB-1:0]   cidx_r,   cidx_nxt;

  logic [MB+3:0]   prod;
  logic            fits;
  logic [MB-1:0]   mant_signed;
  gwt_pkg::result_t num_code, num_bare, cmt_start;
  gwt_pkg::result_t r0, r1;
  logic [1:0]      cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= gwt_pkg::MODE_IDLE;
      letter_r <= 8'd0;
      phase_r  <= gwt_pkg::PH_START;
      neg_r    <= 1'b0;
      seen_r   <= 1'b0;
      acc_r    <= '0;
      frac_r   <= 4'd0;
      ovf_r    <= 1'b0;
      cidx_r   <= '0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      letter_r <= letter_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      seen_r   <= seen_nxt;
      acc_r    <= acc_nxt;
      frac_r   <= frac_nxt;
      ovf_r    <= ovf_nxt;
      cidx_r   <= cidx_nxt;
    end
  end

  // times-ten plus digit; saturation check against the magnitude limit
  assign prod = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + (MB+4)'(ch - gwt_pkg::CH_0);
  assign fits = (prod <= (MB+4)'(gwt_pkg::MAG_MAX));
  assign mant_signed = neg_r ? (MB'(0) - acc_r) : acc_r;

  assign num_code  = gwt_pkg::mk_number(gwt_pkg::KIND_CODE, letter_r, seen_r,
                                        mant_signed, frac_r, ovf_r);
  assign num_bare  = gwt_pkg::mk_number(gwt_pkg::KIND_NUMBER, 8'd0, 1'b1,
                                        mant_signed, frac_r, ovf_r);
  assign cmt_start = gwt_pkg::mk_comment(gwt_pkg::KIND_CMT_START, cidx_r, 8'd0);

  always_comb begin
    logic do_take;
    logic do_fresh;
    logic do_clear;
    do_take    = 1'b0;
    do_fresh   = 1'b0;
    do_clear   = 1'b0;
    mode_nxt   = mode_r;
    letter_nxt = letter_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    seen_nxt   = seen_r;
    acc_nxt    = acc_r;
    frac_nxt   = frac_r;
    ovf_nxt    = ovf_r;
    cidx_nxt   = cidx_r;
    r0         = num_code;
    r1         = cmt_start;
    cnt        = 2'd0;

    if (eos) begin
      unique case (mode_r)
        gwt_pkg::MODE_CODE: begin
          r0  = num_code;
          cnt = 2'd1;
        end
        gwt_pkg::MODE_SPACE: begin
          r0  = num_bare;
          cnt = seen_r ? 2'd1 : 2'd0;
        end
        gwt_pkg::MODE_COMMENT: begin
          r0  = gwt_pkg::mk_comment(gwt_pkg::KIND_CMT_END, cidx_r, 8'd0);
          cnt = 2'd1;
        end
        default: cnt = 2'd0;
      endcase
      mode_nxt   = gwt_pkg::MODE_IDLE;
      letter_nxt = 8'd0;
      do_clear   = 1'b1;
      cidx_nxt   = '0;
    end else begin
      unique case (mode_r)
        gwt_pkg::MODE_COMMENT: begin
          cnt = 2'd1;
          if (ch == gwt_pkg::CH_RPAREN) begin
            r0       = gwt_pkg::mk_comment(gwt_pkg::KIND_CMT_END, cidx_r, 8'd0);
            cidx_nxt = CB'(cidx_r + 1'b1);
            mode_nxt = gwt_pkg::MODE_IDLE;
          end else begin
            r0 = gwt_pkg::mk_comment(gwt_pkg::KIND_CMT_BYTE, cidx_r, ch);
          end
        end
        gwt_pkg::MODE_CODE: begin
          if (gwt_pkg::is_num_char(ch)) begin
            do_take = 1'b1;
          end else begin
            r0         = num_code;
            cnt        = 2'd1;
            letter_nxt = 8'd0;
            do_clear   = 1'b1;
            do_fresh   = 1'b1;
          end
        end
        gwt_pkg::MODE_SPACE: begin
          if (gwt_pkg::is_num_char(ch)) begin
            do_take = 1'b1;
          end else if (ch != gwt_pkg::CH_SPACE) begin
            r0       = num_bare;
            cnt      = seen_r ? 2'd1 : 2'd0;
            do_clear = 1'b1;
            do_fresh = 1'b1;
          end
        end
        default: do_fresh = 1'b1;
      endcase
    end

    if (do_take) begin
      seen_nxt = 1'b1;
      if (ch == gwt_pkg::CH_MINUS) begin
        if (phase_r == gwt_pkg::PH_START) begin
          neg_nxt   = 1'b1;
          phase_nxt = gwt_pkg::PH_INT;
        end else begin
          phase_nxt = gwt_pkg::PH_DONE;
        end
      end else if (ch == gwt_pkg::CH_DOT) begin
        if (phase_r == gwt_pkg::PH_START || phase_r == gwt_pkg::PH_INT) begin
          phase_nxt = gwt_pkg::PH_FRAC;
        end else begin
          phase_nxt = gwt_pkg::PH_DONE;
        end
      end else if (phase_r == gwt_pkg::PH_START || phase_r == gwt_pkg::PH_INT) begin
        phase_nxt = gwt_pkg::PH_INT;
        if (fits) begin
          acc_nxt = prod[MB-1:0];
        end else begin
          acc_nxt = gwt_pkg::MAG_MAX;
          ovf_nxt = 1'b1;
        end
      end else if (phase_r == gwt_pkg::PH_FRAC) begin
        if (fits && frac_r < gwt_pkg::FRAC_MAX) begin
          acc_nxt  = prod[MB-1:0];
          frac_nxt = frac_r + 4'd1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
    end

    if (do_clear) begin
      phase_nxt = gwt_pkg::PH_START;
      neg_nxt   = 1'b0;
      seen_nxt  = 1'b0;
      acc_nxt   = '0;
      frac_nxt  = 4'd0;
      ovf_nxt   = 1'b0;
    end

    // byte that ends a token is handled as if idle
    if (do_fresh) begin
      if (gwt_pkg::is_code_letter(ch)) begin
        mode_nxt   = gwt_pkg::MODE_CODE;
        letter_nxt = ch;
        phase_nxt  = gwt_pkg::PH_START;
        neg_nxt    = 1'b0;
        seen_nxt   = 1'b0;
        acc_nxt    = '0;
        frac_nxt   = 4'd0;
        ovf_nxt    = 1'b0;
      end else if (ch == gwt_pkg::CH_SPACE) begin
        mode_nxt  = gwt_pkg::MODE_SPACE;
        phase_nxt = gwt_pkg::PH_START;
        neg_nxt   = 1'b0;
        seen_nxt  = 1'b0;
        acc_nxt   = '0;
        frac_nxt  = 4'd0;
        ovf_nxt   = 1'b0;
      end else if (ch == gwt_pkg::CH_LPAREN) begin
        mode_nxt = gwt_pkg::MODE_COMMENT;
        if (cnt == 2'd0) begin
          r0  = cmt_start;
          cnt = 2'd1;
        end else begin
          r1  = cmt_start;
          cnt = 2'd2;
        end
      end else begin
        mode_nxt = gwt_pkg::MODE_IDLE;
      end
    end

    r0.last = (cnt == 2'd1);
    r1.last = 1'b1;
  end

  always_comb begin
    push       = '0;
    push.count = fire ? cnt : 2'd0;
    push.r0    = r0;
    push.r1    = r1;
  end

  `GWT_ASSERT_NXT(a_eos_resets, fire && eos,
                  mode_r == gwt_pkg::MODE_IDLE && cidx_r == '0,
                  "flush did not return to idle with comment count cleared")
  `GWT_ASSERT_NXT(a_rparen_closes,
                  fire && !eos && mode_r == gwt_pkg::MODE_COMMENT && ch == gwt_pkg::CH_RPAREN,
                  mode_r == gwt_pkg::MODE_IDLE,
                  "closing paren did not leave comment mode")
  `GWT_ASSERT_IMP(a_two_only_cstart, push.count == 2'd2,
                  push.r1.kind == gwt_pkg::KIND_CMT_START,
                  "second result of a byte is not a comment start")

endmodule

`default_nettype wire

/* hdl/gwt_result_fifo.sv */
// Four-entry result queue between the parser and the result channel.
// Depends on gwt_pkg, gwt_out_if and gcode_word_tokenizer_assert.svh.
`default_nettype none
`include "gcode_word_tokenizer_assert.svh"

module gwt_result_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire gwt_pkg::push_t  push,
  output logic                 room,
  gwt_out_if.source            out_bus
);

  gwt_pkg::result_t mem [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r,  count_nxt;
  logic       pop;
  gwt_pkg::result_t head;

  assign pop  = out_bus.valid && out_bus.ready;
  // room for two results, decided from registered fill only
  assign room = (count_r <= 3'd2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + 2'(push.count);
    rd_ptr_nxt = rd_ptr_r + 2'(pop);
    count_nxt  = count_r + 3'(push.count) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[2'(wr_ptr_r + 2'd1)] <= push.r1;
    end
  end

  assign head = mem[rd_ptr_r];

  assign out_bus.valid         = (count_r != 3'd0);
  assign out_bus.kind          = head.kind;
  assign out_bus.letter        = head.letter;
  assign out_bus.has_value     = head.has_value;
  assign out_bus.mantissa      = head.mantissa;
  assign out_bus.frac_digits   = head.frac_digits;
  assign out_bus.overflow      = head.overflow;
  assign out_bus.comment_index = head.comment_index;
  assign out_bus.comment_byte  = head.comment_byte;
  assign out_bus.last          = head.last;

  `GWT_ASSERT_IMP(a_push_fits, push.count != 2'd0, count_r <= 3'd2,
                  "results pushed without room in queue")
  `GWT_ASSERT_NXT(a_idle_stays_empty, count_r == 3'd0 && push.count == 2'd0,
                  count_r == 3'd0, "queue filled without a push")
  `GWT_ASSERT_NXT(a_hold_valid, out_bus.valid && !out_bus.ready,
                  out_bus.valid, "result dropped while the sink stalled")

endmodule

`default_nettype wire

/* hdl/gcode_word_tokenizer.sv */
// Top level of the streaming G-code tokenizer.
// Depends on gwt_pkg, gwt_in_if, gwt_out_if, gwt_parse, gwt_result_fifo.
//
//  port     dir   beat carries
//  in_bus   sink  ch (8), end_of_stream (1)
//  out_bus  src   kind, letter, has_value, mantissa (40s), frac_digits,
//                 overflow, comment_index (16), comment_byte, last
//
// One byte per cycle while the queue has room: the parser updates its state
// in the accepting cycle and writes zero, one or two results into a
// four-entry queue, whose head drives out_bus.
// in_bus.ready is high while the queue holds at most two results, so a byte
// producing two results and a stalled sink throttle intake.
// Reset (rst_n low, synchronous) empties the queue and returns to idle.
`default_nettype none

module gcode_word_tokenizer (
  input  wire logic clk,
  input  wire logic rst_n,
  gwt_in_if.sink    in_bus,
  gwt_out_if.source out_bus
);

  gwt_pkg::push_t push;
  logic           room;
  logic           fire;

  assign in_bus.ready = room;
  assign fire         = in_bus.valid && room;

  gwt_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .ch    (in_bus.ch),
    .eos   (in_bus.end_of_stream),
    .push  (push)
  );

  gwt_result_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .out_bus (out_bus)
  );

endmodule

`default_nettype wire
